// ----- hdl/quaternion_rigid_transform_defines.svh -----
// Assertion macros for the quaternion rigid transform block.
// No dependencies; included by modules that carry assertions.
`ifndef QUATERNION_RIGID_TRANSFORM_DEFINES_SVH
`define QUATERNION_RIGID_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
`define QRT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define QRT_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define QRT_ASSERT(label, clk, rst, prop)
`define QRT_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- hdl/qrt_pkg.sv -----
// Shared types, constants and a helper function of the quaternion rigid transform.
// No dependencies.
package qrt_pkg;
   localparam int NumStages = 4;
   localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;
   localparam int CsrAddrWidth = 5;

   typedef enum logic [2:0] {
      CSR_SHIFT_X = 3'd0, CSR_SHIFT_Y = 3'd1, CSR_SHIFT_Z = 3'd2,
      CSR_ROT_X = 3'd3, CSR_ROT_Y = 3'd4, CSR_ROT_Z = 3'd5, CSR_ROT_W = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [31:0] ori_x, ori_y, ori_z, ori_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
      logic signed [31:0] out_ori_x, out_ori_y, out_ori_z, out_ori_w;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] tx, ty, tz;
      logic signed [31:0] rx, ry, rz, rw;
   } xform_type;

   typedef struct packed {
      logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   } matrix_type;

   // Saturates a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [67:0] hi;
      logic signed [67:0] lo;
      hi = 68'sh0_0000_0000_7FFF_FFFF;
      lo = -68'sh0_0000_0000_8000_0000;
      if (v > hi) sat32 = 32'sh7FFF_FFFF;
      else if (v < lo) sat32 = 32'sh8000_0000;
      else sat32 = v[31:0];
   endfunction
endpackage

// ----- hdl/qrt_if.sv -----
// Valid/ready channel interfaces, each carrying one payload struct.
// Depends on qrt_pkg.
interface qrt_req_if;
   logic              valid;
   logic              ready;
   qrt_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface qrt_rsp_if;
   logic              valid;
   logic              ready;
   qrt_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/quaternion_rigid_transform.sv -----
// Quaternion rigid-body transform of one pose per transaction.
// 4 register stages with a fully pipelined multiply stage; the response leaves the last.
// Throughput: one transaction per cycle unless rsp.ready or a configuration write stalls it.
// Matrix registers follow a configuration write through the transform and product registers,
// so the request channel is held off in the cycle right after a write.
// Synchronous active-high reset empties the pipeline and loads the identity transform.
module quaternion_rigid_transform (
   input  logic                              clock,
   input  logic                              reset,
   qrt_req_if.sink                           req,
   qrt_rsp_if.source                         rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [qrt_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   qrt_pkg::xform_type  xform;
   qrt_pkg::matrix_type matrix;
   logic                cfg_busy;

   qrt_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .xform, .matrix, .cfg_busy
   );

   qrt_datapath u_dp (
      .clock, .reset, .xform, .matrix, .cfg_busy, .req, .rsp
   );
endmodule

// ----- hdl/qrt_csr.sv -----
// APB-style register file holding the transform and building its rotation matrix.
// Depends on qrt_pkg. The matrix is registered in two steps after any write.
module qrt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [qrt_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   output qrt_pkg::xform_type                xform,
   output qrt_pkg::matrix_type               matrix,
   output logic                              cfg_busy
);
   qrt_pkg::xform_type xf_ff, xf_in;
   logic signed [63:0] p_ff [0:5];
   logic signed [63:0] p_in [0:5];
   logic signed [63:0] q_ff [0:2];
   logic signed [63:0] q_in [0:2];
   qrt_pkg::matrix_type mat_ff, mat_in;
   logic [2:0] idx;
   logic wr;
   logic busy_ff, busy_in;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // The matrix catches up via the product registers, so a new transaction is held
   // off for the cycle right after the write.
   assign busy_in = wr;

   always_comb begin
      xf_in = xf_ff;
      if (wr) begin
         unique case (idx)
            qrt_pkg::CSR_SHIFT_X: xf_in.tx = csr_pwdata;
            qrt_pkg::CSR_SHIFT_Y: xf_in.ty = csr_pwdata;
            qrt_pkg::CSR_SHIFT_Z: xf_in.tz = csr_pwdata;
            qrt_pkg::CSR_ROT_X: xf_in.rx = csr_pwdata;
            qrt_pkg::CSR_ROT_Y: xf_in.ry = csr_pwdata;
            qrt_pkg::CSR_ROT_Z: xf_in.rz = csr_pwdata;
            qrt_pkg::CSR_ROT_W: xf_in.rw = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         qrt_pkg::CSR_SHIFT_X: csr_prdata = xf_ff.tx;
         qrt_pkg::CSR_SHIFT_Y: csr_prdata = xf_ff.ty;
         qrt_pkg::CSR_SHIFT_Z: csr_prdata = xf_ff.tz;
         qrt_pkg::CSR_ROT_X: csr_prdata = xf_ff.rx;
         qrt_pkg::CSR_ROT_Y: csr_prdata = xf_ff.ry;
         qrt_pkg::CSR_ROT_Z: csr_prdata = xf_ff.rz;
         qrt_pkg::CSR_ROT_W: csr_prdata = xf_ff.rw;
         default: csr_prdata = 32'd0;
      endcase
   end

   // Squares and cross products first, then the floored sums per entry.
   always_comb begin
      p_in[0] = xf_ff.rx * xf_ff.rx;
      p_in[1] = xf_ff.ry * xf_ff.ry;
      p_in[2] = xf_ff.rz * xf_ff.rz;
      p_in[3] = xf_ff.rx * xf_ff.ry;
      p_in[4] = xf_ff.rx * xf_ff.rz;
      p_in[5] = xf_ff.ry * xf_ff.rz;
      q_in[0] = xf_ff.rz * xf_ff.rw;
      q_in[1] = xf_ff.ry * xf_ff.rw;
      q_in[2] = xf_ff.rx * xf_ff.rw;
   end

   always_comb begin
      logic signed [67:0] one;
      logic signed [67:0] xx, yy, zz, xy, xz, yz, zw, yw, xw;
      one = 68'(qrt_pkg::OneQ30);
      xx = 68'(p_ff[0] >>> 29); yy = 68'(p_ff[1] >>> 29); zz = 68'(p_ff[2] >>> 29);
      xy = 68'(p_ff[3] >>> 29); xz = 68'(p_ff[4] >>> 29); yz = 68'(p_ff[5] >>> 29);
      zw = 68'(q_ff[0] >>> 29); yw = 68'(q_ff[1] >>> 29); xw = 68'(q_ff[2] >>> 29);
      mat_in.m00 = qrt_pkg::sat32(one - yy - zz);
      mat_in.m01 = qrt_pkg::sat32(xy - zw);
      mat_in.m02 = qrt_pkg::sat32(xz + yw);
      mat_in.m10 = qrt_pkg::sat32(xy + zw);
      mat_in.m11 = qrt_pkg::sat32(one - xx - zz);
      mat_in.m12 = qrt_pkg::sat32(yz - xw);
      mat_in.m20 = qrt_pkg::sat32(xz - yw);
      mat_in.m21 = qrt_pkg::sat32(yz + xw);
      mat_in.m22 = qrt_pkg::sat32(one - xx - yy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xf_ff <= '0;
         xf_ff.rw <= qrt_pkg::OneQ30;
         busy_ff <= 1'b0;
      end else begin
         xf_ff <= xf_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      q_ff <= q_in;
      mat_ff <= mat_in;
   end

   assign xform = xf_ff;
   assign matrix = mat_ff;
   assign cfg_busy = busy_ff;
endmodule

// ----- hdl/qrt_datapath.sv -----
// Four-stage stallable pipeline: operand prep, products, sums, saturation.
// Depends on qrt_pkg, the qrt_if interfaces and the assertion macro header.
`include "quaternion_rigid_transform_defines.svh"
module qrt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  qrt_pkg::xform_type   xform,
   input  qrt_pkg::matrix_type  matrix,
   input  logic                 cfg_busy,
   qrt_req_if.sink              req,
   qrt_rsp_if.source            rsp
);
   localparam int S = qrt_pkg::NumStages;
   logic [S-1:0] vld_ff, vld_in;
   logic [S-1:0] adv;

   // Stage 1: operands.
   logic [1:0] md1_ff;
   logic signed [32:0] d1_ff [0:2];
   logic signed [32:0] aw1_ff;
   logic signed [31:0] b1_ff [0:3];
   // Stage 2: products.
   logic [1:0] md2_ff;
   logic signed [64:0] pp2_ff [0:8];
   logic signed [64:0] qp2_ff [0:15];
   logic signed [31:0] t2_ff [0:2];
   // Stage 3: sums.
   logic [1:0] md3_ff;
   logic signed [35:0] s3_ff [0:6];
   // Stage 4: output.
   qrt_pkg::rsp_type out_ff;

   logic signed [31:0] m [0:8];

   always_comb begin
      adv[S-1] = !vld_ff[S-1] || rsp.ready;
      for (int k = S - 2; k >= 0; k--) adv[k] = !vld_ff[k] || adv[k+1];
   end
   assign req.ready = adv[0] && !cfg_busy;
   always_comb begin
      vld_in[0] = (req.valid && !cfg_busy) ? 1'b1 : 1'b0;
      for (int k = 1; k < S; k++) vld_in[k] = vld_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < S; k++) if (adv[k]) vld_ff[k] <= vld_in[k];
      end
   end

   assign m = '{matrix.m00, matrix.m01, matrix.m02, matrix.m10, matrix.m11,
                matrix.m12, matrix.m20, matrix.m21, matrix.m22};

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         logic vec;
         logic inv;
         vec = req.data.mode[1];
         inv = req.data.mode[0];
         md1_ff <= req.data.mode;
         d1_ff[0] <= 33'(req.data.pos_x) - ((inv && !vec) ? 33'(xform.tx) : 33'sd0);
         d1_ff[1] <= 33'(req.data.pos_y) - ((inv && !vec) ? 33'(xform.ty) : 33'sd0);
         d1_ff[2] <= 33'(req.data.pos_z) - ((inv && !vec) ? 33'(xform.tz) : 33'sd0);
         aw1_ff <= inv ? -33'(xform.rw) : 33'(xform.rw);
         b1_ff <= '{req.data.ori_w, req.data.ori_x, req.data.ori_y, req.data.ori_z};
      end
   end

   // Products: index 3*i+j is the term for output i and position j.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         logic signed [32:0] a [0:3];
         logic fwd_pose;
         a = '{aw1_ff, 33'(xform.rx), 33'(xform.ry), 33'(xform.rz)};
         fwd_pose = !md1_ff[1] && !md1_ff[0];
         md2_ff <= md1_ff;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pp2_ff[3*i+j] <= md1_ff[0] ? 65'(m[3*j+i] * d1_ff[j])
                                          : 65'(m[3*i+j] * d1_ff[j]);
            end
         end
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               qp2_ff[4*i+j] <= 65'(a[i] * 33'(b1_ff[j]));
         t2_ff[0] <= fwd_pose ? xform.tx : 32'sd0;
         t2_ff[1] <= fwd_pose ? xform.ty : 32'sd0;
         t2_ff[2] <= fwd_pose ? xform.tz : 32'sd0;
      end
   end

   // Quaternion a = (w,x,y,z) index 0..3, b = (w,x,y,z) index 0..3.
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         logic signed [35:0] f [0:15];
         logic signed [35:0] g [0:8];
         for (int k = 0; k < 16; k++) f[k] = 36'(qp2_ff[k] >>> 30);
         for (int k = 0; k < 9; k++) g[k] = 36'(pp2_ff[k] >>> 30);
         md3_ff <= md2_ff;
         for (int i = 0; i < 3; i++)
            s3_ff[i] <= g[3*i] + g[3*i+1] + g[3*i+2] + 36'(t2_ff[i]);
         s3_ff[3] <= f[0*4+1] + f[1*4+0] + f[2*4+3] - f[3*4+2];
         s3_ff[4] <= f[0*4+2] - f[1*4+3] + f[2*4+0] + f[3*4+1];
         s3_ff[5] <= f[0*4+3] + f[1*4+2] - f[2*4+1] + f[3*4+0];
         s3_ff[6] <= f[0*4+0] - f[1*4+1] - f[2*4+2] - f[3*4+3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         logic vec;
         vec = md3_ff[1];
         out_ff.out_pos_x <= qrt_pkg::sat32(68'(s3_ff[0]));
         out_ff.out_pos_y <= qrt_pkg::sat32(68'(s3_ff[1]));
         out_ff.out_pos_z <= qrt_pkg::sat32(68'(s3_ff[2]));
         out_ff.out_ori_x <= vec ? 32'sd0 : qrt_pkg::sat32(68'(s3_ff[3]));
         out_ff.out_ori_y <= vec ? 32'sd0 : qrt_pkg::sat32(68'(s3_ff[4]));
         out_ff.out_ori_z <= vec ? 32'sd0 : qrt_pkg::sat32(68'(s3_ff[5]));
         out_ff.out_ori_w <= vec ? 32'sd0 : qrt_pkg::sat32(68'(s3_ff[6]));
      end
   end

   assign rsp.valid = vld_ff[S-1];
   assign rsp.data = out_ff;

   `QRT_ASSERT(a_hold_on_stall, clock, reset, rsp.valid && !rsp.ready |=> rsp.valid)
   `QRT_ASSERT(a_no_accept_when_full, clock, reset, (&vld_ff) && !rsp.ready |-> !req.ready)
   `QRT_ASSERT(a_flow, clock, reset, req.valid && req.ready |=> vld_ff[0])
   `QRT_ASSERT_RST(a_reset_empty, clock, $past(reset) |-> vld_ff == '0)
endmodule

// ----- dv/tb_quaternion_rigid_transform.sv -----
// Self-checking testbench of the quaternion rigid transform: random and directed poses against a
// bit-exact predictor, with the transform set over the APB-style port.
// Depends on qrt_pkg, the qrt_req_if/qrt_rsp_if interfaces and the block itself.
module tb_quaternion_rigid_transform;
   localparam logic [1:0] ModeFwdPose = 2'd0;
   localparam logic [1:0] ModeInvPose = 2'd1;
   localparam logic [1:0] ModeFwdVec  = 2'd2;
   localparam logic [1:0] ModeInvVec  = 2'd3;
   localparam logic [2:0] UnusedCsrIdx = 3'd7;
   localparam int SettleCycles = 8;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [qrt_pkg::CsrAddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   qrt_req_if req_ch();
   qrt_rsp_if rsp_ch();

   quaternion_rigid_transform u_dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Transform as the block should hold it.
   logic signed [31:0] xform_regs [7];

   qrt_pkg::req_type pending_poses[$];
   qrt_pkg::rsp_type expected_poses[$];
   int      error_count;
   int      result_count;
   int      mode_count [4];
   bit      hold_sender;
   bit      no_idle;
   int      send_gap;
   int      recv_gap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Timeout at %0t", $time);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic longint floor_q(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic qrt_pkg::rsp_type predict_pose(qrt_pkg::req_type r);
      qrt_pkg::rsp_type o;
      longint t [3], p [3], m [3][3], acc;
      longint rx, ry, rz, rw, aw, bx, by, bz, bw;
      bit inv, vec;
      inv = r.mode[0];
      vec = r.mode[1];
      for (int i = 0; i < 3; i++) t[i] = vec ? 0 : longint'(xform_regs[i]);
      p[0] = r.pos_x; p[1] = r.pos_y; p[2] = r.pos_z;
      rx = xform_regs[qrt_pkg::CSR_ROT_X]; ry = xform_regs[qrt_pkg::CSR_ROT_Y];
      rz = xform_regs[qrt_pkg::CSR_ROT_Z]; rw = xform_regs[qrt_pkg::CSR_ROT_W];
      m[0][0] = clamp32(64'sd1073741824 - floor_q(ry*ry, 29) - floor_q(rz*rz, 29));
      m[0][1] = clamp32(floor_q(rx*ry, 29) - floor_q(rz*rw, 29));
      m[0][2] = clamp32(floor_q(rx*rz, 29) + floor_q(ry*rw, 29));
      m[1][0] = clamp32(floor_q(rx*ry, 29) + floor_q(rz*rw, 29));
      m[1][1] = clamp32(64'sd1073741824 - floor_q(rx*rx, 29) - floor_q(rz*rz, 29));
      m[1][2] = clamp32(floor_q(ry*rz, 29) - floor_q(rx*rw, 29));
      m[2][0] = clamp32(floor_q(rx*rz, 29) - floor_q(ry*rw, 29));
      m[2][1] = clamp32(floor_q(ry*rz, 29) + floor_q(rx*rw, 29));
      m[2][2] = clamp32(64'sd1073741824 - floor_q(rx*rx, 29) - floor_q(ry*ry, 29));
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            if (inv) acc += floor_q(m[j][i] * (p[j] - t[j]), 30);
            else acc += floor_q(m[i][j] * p[j], 30);
         end
         if (!inv) acc += t[i];
         if (i == 0) o.out_pos_x = clamp32(acc);
         else if (i == 1) o.out_pos_y = clamp32(acc);
         else o.out_pos_z = clamp32(acc);
      end
      if (vec) begin
         o.out_ori_x = '0; o.out_ori_y = '0; o.out_ori_z = '0; o.out_ori_w = '0;
      end else begin
         // The inverse uses the conjugate that negates w only, kept at full width.
         aw = inv ? -rw : rw;
         bx = r.ori_x; by = r.ori_y; bz = r.ori_z; bw = r.ori_w;
         o.out_ori_x = clamp32(floor_q(aw*bx, 30) + floor_q(rx*bw, 30)
                               + floor_q(ry*bz, 30) - floor_q(rz*by, 30));
         o.out_ori_y = clamp32(floor_q(aw*by, 30) - floor_q(rx*bz, 30)
                               + floor_q(ry*bw, 30) + floor_q(rz*bx, 30));
         o.out_ori_z = clamp32(floor_q(aw*bz, 30) + floor_q(rx*by, 30)
                               - floor_q(ry*bx, 30) + floor_q(rz*bw, 30));
         o.out_ori_w = clamp32(floor_q(aw*bw, 30) - floor_q(rx*bx, 30)
                               - floor_q(ry*by, 30) - floor_q(rz*bz, 30));
      end
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sh0;
         3: return 32'sh4000_0000;
         4: return 32'shC000_0000;
         5: return $signed($urandom_range(0, 2000)) - 1000;
         6: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
         default: return $urandom;
      endcase
   endfunction

   // Driver: predicts at the accepting edge, then presents the next pose.
   always @(posedge clock) begin
      logic             next_valid;
      qrt_pkg::req_type next_data;
      next_valid = req_ch.valid;
      next_data = req_ch.data;
      if (reset) begin
         next_valid = 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_poses.push_back(predict_pose(req_ch.data));
            mode_count[req_ch.data.mode]++;
            next_valid = 1'b0;
            send_gap = pick_gap();
         end
         if (!next_valid) begin
            if (send_gap > 0) send_gap--;
            else if (!hold_sender && pending_poses.size() > 0) begin
               next_data = pending_poses.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_ch.valid <= next_valid;
      req_ch.data <= next_data;
   end

   // Monitor: compares each accepted result with the oldest prediction.
   always @(posedge clock) begin
      qrt_pkg::rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            if (expected_poses.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result %h", $time, rsp_ch.data);
            end else begin
               want = expected_poses.pop_front();
               if (want.out_pos_x !== rsp_ch.data.out_pos_x) begin
                  error_count++;
                  $display("%0t: out_pos_x expected %h actual %h", $time,
                           want.out_pos_x, rsp_ch.data.out_pos_x);
               end
               if (want.out_pos_y !== rsp_ch.data.out_pos_y) begin
                  error_count++;
                  $display("%0t: out_pos_y expected %h actual %h", $time,
                           want.out_pos_y, rsp_ch.data.out_pos_y);
               end
               if (want.out_pos_z !== rsp_ch.data.out_pos_z) begin
                  error_count++;
                  $display("%0t: out_pos_z expected %h actual %h", $time,
                           want.out_pos_z, rsp_ch.data.out_pos_z);
               end
               if (want.out_ori_x !== rsp_ch.data.out_ori_x) begin
                  error_count++;
                  $display("%0t: out_ori_x expected %h actual %h", $time,
                           want.out_ori_x, rsp_ch.data.out_ori_x);
               end
               if (want.out_ori_y !== rsp_ch.data.out_ori_y) begin
                  error_count++;
                  $display("%0t: out_ori_y expected %h actual %h", $time,
                           want.out_ori_y, rsp_ch.data.out_ori_y);
               end
               if (want.out_ori_z !== rsp_ch.data.out_ori_z) begin
                  error_count++;
                  $display("%0t: out_ori_z expected %h actual %h", $time,
                           want.out_ori_z, rsp_ch.data.out_ori_z);
               end
               if (want.out_ori_w !== rsp_ch.data.out_ori_w) begin
                  error_count++;
                  $display("%0t: out_ori_w expected %h actual %h", $time,
                           want.out_ori_w, rsp_ch.data.out_ori_w);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            recv_gap = pick_gap();
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= qrt_pkg::CsrAddrWidth'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx < UnusedCsrIdx) xform_regs[idx] = value;
   endtask

   // Sampled on the falling edge so that the driver's updates of the same cycle are seen.
   task automatic wait_drained();
      while (pending_poses.size() > 0 || req_ch.valid || expected_poses.size() > 0)
         @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic load_transform(logic signed [31:0] tx, ty, tz, rx, ry, rz, rw);
      write_reg(qrt_pkg::CSR_SHIFT_X, tx);
      write_reg(qrt_pkg::CSR_SHIFT_Y, ty);
      write_reg(qrt_pkg::CSR_SHIFT_Z, tz);
      write_reg(qrt_pkg::CSR_ROT_X, rx);
      write_reg(qrt_pkg::CSR_ROT_Y, ry);
      write_reg(qrt_pkg::CSR_ROT_Z, rz);
      write_reg(qrt_pkg::CSR_ROT_W, rw);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic qrt_pkg::req_type make_pose(logic [1:0] mode, logic signed [31:0] v);
      qrt_pkg::req_type r;
      r.mode = mode;
      r.pos_x = v; r.pos_y = -v; r.pos_z = v;
      r.ori_x = v; r.ori_y = v; r.ori_z = -v; r.ori_w = v;
      return r;
   endfunction

   function automatic qrt_pkg::req_type random_pose();
      qrt_pkg::req_type r;
      r.mode = $urandom_range(0, 3);
      r.pos_x = pick_word(); r.pos_y = pick_word(); r.pos_z = pick_word();
      r.ori_x = pick_word(); r.ori_y = pick_word();
      r.ori_z = pick_word(); r.ori_w = pick_word();
      return r;
   endfunction

   task automatic run_random(int count);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < count; k++) pending_poses.push_back(random_pose());
      wait_drained();
      no_idle = 1'b0;
   endtask

   initial begin
      logic [1:0] modes [4];
      logic signed [31:0] edge_vals [5];
      modes = '{ModeFwdPose, ModeInvPose, ModeFwdVec, ModeInvVec};
      edge_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0001_0000, 32'shFFFF_FFFF};
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      hold_sender = 1'b0;
      no_idle = 1'b0;
      error_count = 0;
      result_count = 0;
      mode_count = '{0, 0, 0, 0};
      for (int i = 0; i < 7; i++) xform_regs[i] = '0;
      xform_regs[qrt_pkg::CSR_ROT_W] = qrt_pkg::OneQ30;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes in every mode under the reset identity transform.
      foreach (modes[m])
         foreach (edge_vals[e]) pending_poses.push_back(make_pose(modes[m], edge_vals[e]));
      wait_drained();

      // A write past the last register must leave the transform alone.
      write_reg(UnusedCsrIdx, 32'hDEAD_BEEF);
      // 90 degrees about z with an offset; midway the sender holds until all results drain.
      load_transform(32'sh0001_0000, -32'sh0002_0000, 32'sh7FFF_FFFF,
                     32'sh0, 32'sh0, 32'sh2D41_3CCD, 32'sh2D41_3CCD);
      for (int k = 0; k < 60; k++) pending_poses.push_back(random_pose());
      repeat (20) @(posedge clock);
      hold_sender = 1'b1;
      while (expected_poses.size() > 0 || req_ch.valid) @(negedge clock);
      hold_sender = 1'b0;
      wait_drained();
      run_random(140);

      // Extremes of every register, which drive the matrix into saturation.
      load_transform(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      run_random(200);
      load_transform(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      run_random(200);
      load_transform(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000);
      run_random(150);
      for (int ph = 0; ph < 4; ph++) begin
         load_transform(pick_word(), pick_word(), pick_word(),
                        pick_word(), pick_word(), pick_word(), pick_word());
         run_random(180);
      end
      // Back to the identity transform for the last stretch.
      load_transform(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, qrt_pkg::OneQ30);
      run_random(120);

      $display("Checked %0d results over 10 transform settings (modes 0..3: %0d %0d %0d %0d).",
               result_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
